/* design/wlrl_pkg.sv */
`default_nettype none
package wlrl_pkg;

  // log geometry
  localparam int SLOTS        = 128;
  localparam int RECORD_BYTES = 5;

  localparam int PAY_W  = 8 * RECORD_BYTES;
  localparam int SLOT_W = PAY_W + 8;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int BCNT_W = $clog2(RECORD_BYTES + 1);

  // port field widths
  localparam int KIND_W      = 2;
  localparam int REC_W       = 40;
  localparam int STATUS_W    = 3;
  localparam int SLOT_FW     = 7;
  localparam int CRC_W       = 8;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_PAD_W   = OUT_DATA_W - REC_W - SLOT_FW - CRC_W;

  // crc-8, msb first, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // bit of kind that marks a forced save
  localparam int FORCE_BIT = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SAVE  = 2'd1,
    KIND_FORCE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SKIPPED = 3'd0,
    ST_WRITTEN = 3'd1,
    ST_ERASED  = 3'd2,
    ST_LOADED  = 3'd3,
    ST_FAILED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_LD_WAIT = 3'd1,
    S_LD_CRC  = 3'd2,
    S_SV_CRC  = 3'd3,
    S_RESP    = 3'd4
  } state_t;

  // slot store access
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              erase;
    logic [IDX_W-1:0]  addr;
    logic [SLOT_W-1:0] wdata;
  } store_req_t;

  // crc unit start
  typedef struct packed {
    logic             start;
    logic [PAY_W-1:0] data;
  } crc_req_t;

endpackage
`default_nettype wire

/* design/wlrl_crc.sv */
`default_nettype none
module wlrl_crc
  import wlrl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire crc_req_t   req,
  output logic            done,
  output logic [CRC_W-1:0] crc
);

  logic [7:0]        crc_r;
  logic [PAY_W-1:0]  data_r;
  logic [BCNT_W-1:0] cnt_r;
  logic              done_r;

  // one record byte through the crc register, bit by bit
  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] b);
    logic [7:0] c;
    c = c_in ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // byte counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == BCNT_W'(1));
      if (req.start) begin
        cnt_r <= BCNT_W'(RECORD_BYTES);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // first byte sits on top, shift it out one byte a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      crc_r  <= CRC_INIT;
      data_r <= req.data;
    end else if (cnt_r != '0) begin
      crc_r  <= crc8_byte(crc_r, data_r[PAY_W-1 -: 8]);
      data_r <= data_r << 8;
    end
  end

  assign done = done_r;
  assign crc  = crc_r;

endmodule
`default_nettype wire

/* design/wlrl_store.sv */
`default_nettype none
module wlrl_store
  import wlrl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire store_req_t  req,
  output logic [SLOT_W-1:0] rd_data
);

  logic [SLOT_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOT_W-1:0] rd_q_r;
  logic              rd_vld_r;

  // slot array, one port, registered read
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rd_q_r   <= mem[req.addr];
      rd_vld_r <= valid_r[req.addr];
    end
  end

  // erase clears every mark, a write sets its own
  always_comb begin
    valid_nxt = req.erase ? '0 : valid_r;
    if (req.wr) begin
      valid_nxt[req.addr] = 1'b1;
    end
  end

  // written marks; an unmarked slot reads as erased
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '1;

endmodule
`default_nettype wire

/* design/wlrl_ctrl.sv */
`default_nettype none
module wlrl_ctrl
  import wlrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [KIND_W-1:0]     in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [STATUS_W-1:0]        out_tuser,
  output crc_req_t                   crc_req,
  input  wire logic                  crc_done,
  input  wire logic [CRC_W-1:0]      crc_value,
  output store_req_t                 st_req,
  input  wire logic [SLOT_W-1:0]     rd_data
);

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      next_slot_r, next_slot_nxt;
  logic [CRC_W-1:0]      last_crc_r, last_crc_nxt;
  logic [PAY_W-1:0]      prev_pay_r, prev_pay_nxt;
  logic [CRC_W-1:0]      prev_crc_r, prev_crc_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [PAY_W-1:0]      rec_r, rec_nxt;
  logic                  force_r, force_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [PAY_W-1:0]      res_rec_r, res_rec_nxt;
  logic [IDX_W-1:0]      res_slot_r, res_slot_nxt;
  logic [CRC_W-1:0]      res_crc_r, res_crc_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]   out_user_r, out_user_nxt;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_slot_r <= '0;
      last_crc_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_slot_r <= next_slot_nxt;
      last_crc_r  <= last_crc_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    prev_pay_r   <= prev_pay_nxt;
    prev_crc_r   <= prev_crc_nxt;
    slot_r       <= slot_nxt;
    rec_r        <= rec_nxt;
    force_r      <= force_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    res_slot_r   <= res_slot_nxt;
    res_crc_r    <= res_crc_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  // sequencer: load scan and save
  always_comb begin
    logic             erase_now;
    logic [IDX_W-1:0] waddr;

    erase_now      = 1'b0;
    waddr          = '0;
    state_nxt      = state_r;
    n_nxt          = n_r;
    next_slot_nxt  = next_slot_r;
    last_crc_nxt   = last_crc_r;
    prev_pay_nxt   = prev_pay_r;
    prev_crc_nxt   = prev_crc_r;
    slot_nxt       = slot_r;
    rec_nxt        = rec_r;
    force_nxt      = force_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    res_slot_nxt   = res_slot_r;
    res_crc_nxt    = res_crc_r;
    out_vld_nxt    = out_vld_r & ~out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    crc_req        = '0;
    st_req         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == KIND_LOAD) begin
            // start the scan at slot 0
            st_req.rd   = 1'b1;
            st_req.addr = '0;
            n_nxt       = '0;
            state_nxt   = S_LD_WAIT;
          end else begin
            // bit 1 marks a forced save, so code 3 behaves as one
            crc_req.start = 1'b1;
            crc_req.data  = in_tdata[PAY_W-1:0];
            rec_nxt       = in_tdata[PAY_W-1:0];
            force_nxt     = in_tuser[FORCE_BIT];
            state_nxt     = S_SV_CRC;
          end
        end
      end

      S_LD_WAIT: begin
        slot_nxt      = rd_data;
        crc_req.start = 1'b1;
        crc_req.data  = rd_data[SLOT_W-1:8];
        state_nxt     = S_LD_CRC;
      end

      S_LD_CRC: begin
        if (crc_done) begin
          if (crc_value == slot_r[7:0]) begin
            prev_pay_nxt = slot_r[SLOT_W-1:8];
            prev_crc_nxt = slot_r[7:0];
            if (n_r == IDX_W'(SLOTS - 1)) begin
              // every slot good: return the last one, log counts as full
              res_status_nxt = ST_LOADED;
              res_rec_nxt    = slot_r[SLOT_W-1:8];
              res_slot_nxt   = n_r;
              res_crc_nxt    = slot_r[7:0];
              last_crc_nxt   = slot_r[7:0];
              next_slot_nxt  = CNT_W'(SLOTS);
              state_nxt      = S_RESP;
            end else begin
              n_nxt       = n_r + 1'b1;
              st_req.rd   = 1'b1;
              st_req.addr = n_r + 1'b1;
              state_nxt   = S_LD_WAIT;
            end
          end else if (n_r == '0) begin
            // first slot already bad
            res_status_nxt = ST_FAILED;
            res_rec_nxt    = '0;
            res_slot_nxt   = '0;
            res_crc_nxt    = crc_value;
            next_slot_nxt  = '0;
            state_nxt      = S_RESP;
          end else begin
            res_status_nxt = ST_LOADED;
            res_rec_nxt    = prev_pay_r;
            res_slot_nxt   = n_r - 1'b1;
            res_crc_nxt    = prev_crc_r;
            last_crc_nxt   = prev_crc_r;
            next_slot_nxt  = CNT_W'(n_r);
            state_nxt      = S_RESP;
          end
        end
      end

      S_SV_CRC: begin
        if (crc_done) begin
          if (!force_r && crc_value == last_crc_r) begin
            // unchanged record
            res_status_nxt = ST_SKIPPED;
            res_rec_nxt    = '0;
            res_slot_nxt   = '0;
            res_crc_nxt    = crc_value;
          end else begin
            // write the next slot; forced or full: erase all and write slot 0
            erase_now      = force_r || (next_slot_r >= CNT_W'(SLOTS));
            waddr          = erase_now ? '0 : next_slot_r[IDX_W-1:0];
            st_req.wr      = 1'b1;
            st_req.erase   = erase_now;
            st_req.addr    = waddr;
            st_req.wdata   = {rec_r, crc_value};
            next_slot_nxt  = CNT_W'(waddr) + 1'b1;
            last_crc_nxt   = crc_value;
            res_status_nxt = erase_now ? ST_ERASED : ST_WRITTEN;
            res_rec_nxt    = '0;
            res_slot_nxt   = waddr;
            res_crc_nxt    = crc_value;
          end
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {{OUT_PAD_W{1'b0}}, res_crc_r, SLOT_FW'(res_slot_r),
                          REC_W'(res_rec_r)};
          out_user_nxt = res_status_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

/* design/wear_leveled_record_log_unit.sv */
`default_nettype none
// Append-only log of settings records with a CRC-8 per slot (poly 0x07, init 0xFF,
// msb first). A request with tuser kind 0 loads: slots are scanned from 0, each read
// from the single-port slot memory and checked by a byte-serial crc unit (a read,
// then the crc over each record byte in turn, then a compare with the stored crc);
// the last good slot is returned. Kind 1 saves if the crc differs from the last one
// written or loaded, kind 2 (and 3) saves unconditionally; a forced save or a save
// into a full log erases the log through per-slot written marks in the same cycle
// as it writes slot 0. One request is worked on at a time; a new request is taken
// while the previous result still waits in the output register. After reset every
// slot reads as erased (all ones).
module wear_leveled_record_log_unit
  import wlrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // record_in
  input  wire logic [KIND_W-1:0]     in_tuser,   // kind
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // record_out, slot_used, crc_value, pad
  output logic [STATUS_W-1:0]        out_tuser   // status
);

  crc_req_t          crc_req;
  logic              crc_done;
  logic [CRC_W-1:0]  crc_value;
  store_req_t        st_req;
  logic [SLOT_W-1:0] rd_data;

  // sequencer
  wlrl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .crc_req    (crc_req),
    .crc_done   (crc_done),
    .crc_value  (crc_value),
    .st_req     (st_req),
    .rd_data    (rd_data)
  );

  // byte-serial crc
  wlrl_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (crc_req),
    .done  (crc_done),
    .crc   (crc_value)
  );

  // slot memory
  wlrl_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire
